// File: src/irc_tok_pkg.sv
// Package for the IRC parameter tokenizer: result types, character codes
// and the result builder. No dependencies; used by core, queue, top and bench.
package irc_tok_pkg;

	localparam int unsigned MAX_MESSAGE_BYTES_DEF = 512;
	localparam logic [4:0]  LIMIT_RESET           = 5'd19;
	localparam logic [4:0]  LIMIT_MIN             = 5'd1;
	localparam logic [4:0]  LIMIT_MAX             = 5'd30;
	localparam logic [4:0]  LIMIT_RAW_TOP         = 5'd31;

	localparam logic [7:0]  CH_COLON = 8'h3A;
	localparam logic [7:0]  CH_SPACE = 8'h20;
	localparam logic [7:0]  CH_NUL   = 8'h00;

	localparam int unsigned START_W = 9;
	localparam int unsigned LEN_W   = 10;
	localparam int unsigned IDX_W   = 5;

	// result queue geometry
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = 2;
	localparam int unsigned QCNT_W      = 3;

	typedef struct packed {
		logic [START_W-1:0] token_start;
		logic [LEN_W-1:0]   token_length;
		logic [IDX_W-1:0]   token_index;
		logic               is_trailing;
		logic               final_token;
		logic               overlong;
	} res_t;

	// results raised by one message byte, in order
	typedef struct packed {
		logic [1:0] num;
		res_t       r0;
		res_t       r1;
	} push_t;

	// build one result, saturating start and length to their field widths
	function automatic res_t mk_res(logic [31:0] start, logic [31:0] len,
					logic [IDX_W-1:0] idx, logic trail, logic fin, logic ovl);
		res_t r;
		r.token_start  = (start > 32'd511) ? 9'd511 : start[START_W-1:0];
		r.token_length = (len > 32'd1023) ? 10'd1023 : len[LEN_W-1:0];
		r.token_index  = idx;
		r.is_trailing  = trail;
		r.final_token  = fin;
		r.overlong     = ovl;
		return r;
	endfunction

endpackage

// File: src/irc_tok_in_if.sv
// Request channel for message bytes: valid/ready handshake with payload.
// Depends on nothing.
interface irc_tok_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_byte;
	logic       end_of_message;

	modport source (output valid, output char_byte, output end_of_message, input ready);
	modport sink (input valid, input char_byte, input end_of_message, output ready);
endinterface

// File: src/irc_tok_out_if.sv
// Result channel carrying one parameter per request.
// Depends on nothing.
interface irc_tok_out_if;
	logic       valid;
	logic       ready;
	logic [8:0] token_start;
	logic [9:0] token_length;
	logic [4:0] token_index;
	logic       is_trailing;
	logic       final_token;
	logic       overlong;

	modport source (output valid, output token_start, output token_length,
			output token_index, output is_trailing, output final_token,
			output overlong, input ready);
	modport sink (input valid, input token_start, input token_length,
			input token_index, input is_trailing, input final_token,
			input overlong, output ready);
endinterface

// File: src/irc_tok_core.sv
// Byte scanner: input register, message state and result generation.
// Depends on irc_tok_pkg and irc_tok_in_if.
module irc_tok_core #(
	parameter int unsigned MAX_MESSAGE_BYTES = irc_tok_pkg::MAX_MESSAGE_BYTES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [4:0]            cfg_wr_data,
	irc_tok_in_if.sink            msg_in,
	input  logic                  space_ok,
	output irc_tok_pkg::push_t    push
);
	import irc_tok_pkg::*;

	localparam int unsigned OFF_W = $clog2(MAX_MESSAGE_BYTES + 1);
	localparam logic [OFF_W-1:0] OffMax = OFF_W'(MAX_MESSAGE_BYTES);
	localparam logic [OFF_W-1:0] OffOne = OFF_W'(1);

	logic             vld_s1;
	logic [7:0]       byte_s1;
	logic             eom_s1;
	logic             adv;

	logic [4:0]       limit_q;
	logic [4:0]       eff_lim;

	logic [OFF_W-1:0] off_q, ots_q, len_q, trs_q, trl_q;
	logic [OFF_W-1:0] off_n, ots_n, len_n, trs_n, trl_n;
	logic [IDX_W-1:0] seen_q, seen_n;
	logic             open_q, psp_q, intr_q, lim_q, end_q, ovl_q;
	logic             open_n, psp_n, intr_n, lim_n, end_n, ovl_n;

	logic             is_colon, is_space, is_nul, over, absorbing;
	logic             take, do_fin, tb_emit;
	res_t             tb_res, fin_a, fin_b;

	assign adv          = vld_s1 && space_ok;
	assign msg_in.ready = !vld_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (msg_in.ready) begin
			vld_s1 <= msg_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (msg_in.ready && msg_in.valid) begin
			byte_s1 <= msg_in.char_byte;
			eom_s1  <= msg_in.end_of_message;
		end
	end

	// token limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_wr_en) begin
			limit_q <= cfg_wr_data;
		end
	end

	// clamp the limit to 1..30
	always_comb begin
		eff_lim = limit_q;
		if (limit_q < LIMIT_MIN) begin
			eff_lim = LIMIT_MIN;
		end else if (limit_q == LIMIT_RAW_TOP) begin
			eff_lim = LIMIT_MAX;
		end
	end

	// next message state for the byte in s1
	always_comb begin
		off_n  = off_q;
		ots_n  = ots_q;
		len_n  = len_q;
		open_n = open_q;
		seen_n = seen_q;
		psp_n  = psp_q;
		intr_n = intr_q;
		lim_n  = lim_q;
		end_n  = end_q;
		ovl_n  = ovl_q;
		trs_n  = trs_q;
		trl_n  = trl_q;
		tb_emit = 1'b0;

		is_colon  = (byte_s1 == CH_COLON);
		is_space  = (byte_s1 == CH_SPACE);
		is_nul    = (byte_s1 == CH_NUL);
		over      = (off_q >= OffMax);
		absorbing = !intr_q && !lim_q && (seen_q >= eff_lim);
		take      = !end_q && !over && !is_nul;
		do_fin    = !end_q && (eom_s1 || (!over && is_nul));

		// bytes past the buffer only mark the message
		if (!end_q && over) begin
			ovl_n = 1'b1;
		end
		// zero byte ends the message; later bytes wait for the end marker
		if (!end_q && !over && is_nul && !eom_s1) begin
			end_n = 1'b1;
		end

		if (take) begin
			if (!lim_q) begin
				priority if (intr_q) begin
					trl_n = trl_q + OffOne;
				end else if (is_colon && psp_q && (off_q != '0)) begin
					if (absorbing && ((off_q - OffOne) > ots_q)) begin
						len_n = off_q - OffOne - ots_q;
						lim_n = 1'b1;
					end else begin
						if (absorbing) begin
							len_n = '0;
						end
						intr_n = 1'b1;
						trs_n  = off_q + OffOne;
						trl_n  = '0;
					end
				end else if (absorbing) begin
					len_n = len_q + OffOne;
				end else if (is_space) begin
					open_n = 1'b0;
				end else if (open_q) begin
					len_n = len_q + OffOne;
				end else begin
					tb_emit = 1'b1;
					seen_n  = seen_q + 5'd1;
					ots_n   = off_q;
					len_n   = OffOne;
					open_n  = 1'b1;
				end
			end
			psp_n = is_space;
			off_n = off_q + OffOne;
		end
	end

	// results: a closed token, then the final one or two parameters
	always_comb begin
		tb_res = mk_res(32'(ots_q), 32'(len_q), seen_q - 5'd1, 1'b0, 1'b0, ovl_q);
		fin_a  = mk_res(32'(ots_n), 32'(len_n), seen_n - 5'd1, 1'b0, !intr_n, ovl_n);
		fin_b  = mk_res(32'(trs_n), 32'(trl_n), seen_n, 1'b1, 1'b1, ovl_n);

		push.num = 2'd0;
		push.r0  = fin_a;
		push.r1  = fin_b;
		if (adv) begin
			if (tb_emit) begin
				push.r0  = tb_res;
				push.r1  = fin_a;
				push.num = do_fin ? 2'd2 : 2'd1;
			end else if (do_fin) begin
				push.num = intr_n ? 2'd2 : 2'd1;
			end
		end
	end

	// message state; the end of a message puts it back to reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q  <= '0;
			ots_q  <= '0;
			len_q  <= '0;
			open_q <= 1'b1;
			seen_q <= 5'd1;
			psp_q  <= 1'b0;
			intr_q <= 1'b0;
			lim_q  <= 1'b0;
			end_q  <= 1'b0;
			ovl_q  <= 1'b0;
			trs_q  <= '0;
			trl_q  <= '0;
		end else if (adv) begin
			if (eom_s1) begin
				off_q  <= '0;
				ots_q  <= '0;
				len_q  <= '0;
				open_q <= 1'b1;
				seen_q <= 5'd1;
				psp_q  <= 1'b0;
				intr_q <= 1'b0;
				lim_q  <= 1'b0;
				end_q  <= 1'b0;
				ovl_q  <= 1'b0;
				trs_q  <= '0;
				trl_q  <= '0;
			end else begin
				off_q  <= off_n;
				ots_q  <= ots_n;
				len_q  <= len_n;
				open_q <= open_n;
				seen_q <= seen_n;
				psp_q  <= psp_n;
				intr_q <= intr_n;
				lim_q  <= lim_n;
				end_q  <= end_n;
				ovl_q  <= ovl_n;
				trs_q  <= trs_n;
				trl_q  <= trl_n;
			end
		end
	end

endmodule

// File: src/irc_tok_res_fifo.sv
// Four-entry result queue: up to two results in a cycle, one out when ready.
// Depends on irc_tok_pkg and irc_tok_out_if.
module irc_tok_res_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  irc_tok_pkg::push_t push,
	output logic               space_ok,
	irc_tok_out_if.source      tok_out
);
	import irc_tok_pkg::*;

	res_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              pop;
	res_t              head;

	assign space_ok = (cnt_q <= QCNT_W'(QUEUE_DEPTH - 2));
	assign pop      = tok_out.valid && tok_out.ready;
	assign head     = mem_q[rd_q];

	assign tok_out.valid        = (cnt_q != '0);
	assign tok_out.token_start  = head.token_start;
	assign tok_out.token_length = head.token_length;
	assign tok_out.token_index  = head.token_index;
	assign tok_out.is_trailing  = head.is_trailing;
	assign tok_out.final_token  = head.final_token;
	assign tok_out.overlong     = head.overlong;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + QPTR_W'(push.num);
			rd_q  <= rd_q + QPTR_W'(pop);
			cnt_q <= cnt_q + QCNT_W'(push.num) - QCNT_W'(pop);
		end
	end

	// result storage
	always_ff @(posedge clk) begin
		if (push.num != 2'd0) begin
			mem_q[wr_q] <= push.r0;
		end
		if (push.num == 2'd2) begin
			mem_q[wr_q + QPTR_W'(1)] <= push.r1;
		end
	end

endmodule

// File: src/irc_parameter_tokenizer_unit.sv
// IRC parameter tokenizer, top level: wires the byte scanner to the result queue.
// Depends on irc_tok_pkg, the two channel interfaces, irc_tok_core and irc_tok_res_fifo.
//
// Takes one message byte per clock and reports each parameter as start offset
// and length, token 0 first, the colon-introduced trailing parameter last. A
// byte enters the input register when that register is empty or moving on and
// is scanned from there once the queue has room; its results are registered
// into a four-entry queue that feeds the result channel. The scan keeps one
// byte per cycle as long as the queue has two free entries; a byte that closes
// a token and ends the message, or ends a message with a trailing parameter,
// gives two results, and the result channel moves one request per cycle.
// token_limit must be written through cfg_wr_en/cfg_wr_data only while no
// message is in flight; the user is bound to this, the block does not enforce it.
module irc_parameter_tokenizer_unit #(
	parameter int unsigned MAX_MESSAGE_BYTES = irc_tok_pkg::MAX_MESSAGE_BYTES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_wr_en,
	input  logic [4:0]    cfg_wr_data,
	irc_tok_in_if.sink    msg_in,
	irc_tok_out_if.source tok_out
);
	import irc_tok_pkg::*;

	push_t push;
	logic  space_ok;

	irc_tok_core #(
		.MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.msg_in     (msg_in),
		.space_ok   (space_ok),
		.push       (push)
	);

	irc_tok_res_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.space_ok(space_ok),
		.tok_out (tok_out)
	);

endmodule

// File: src/irc_tok_checker.sv
// Port-level checks on the tokenizer's result channel, with the bind that
// attaches them to irc_parameter_tokenizer_unit. Depends on nothing else.
module irc_tok_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [8:0] token_start,
	input logic [9:0] token_length,
	input logic [4:0] token_index,
	input logic       is_trailing,
	input logic       final_token,
	input logic       overlong
);

	// a stalled request keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(token_start)
		&& $stable(token_length) && $stable(token_index) && $stable(is_trailing)
		&& $stable(final_token) && $stable(overlong))
		else $error("result changed while stalled");

	// the trailing parameter always closes the list
	a_trail_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_trailing |-> final_token)
		else $error("trailing parameter not final");

	// trailing parameter never has index 0
	a_trail_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_trailing |-> token_index != 5'd0)
		else $error("trailing parameter at index 0");

	// token 0 starts at the head of the message
	a_tok0_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_trailing && token_index == 5'd0 |-> token_start == 9'd0)
		else $error("token 0 not at offset 0");

endmodule

bind irc_parameter_tokenizer_unit irc_tok_checker u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (tok_out.valid),
	.out_ready   (tok_out.ready),
	.token_start (tok_out.token_start),
	.token_length(tok_out.token_length),
	.token_index (tok_out.token_index),
	.is_trailing (tok_out.is_trailing),
	.final_token (tok_out.final_token),
	.overlong    (tok_out.overlong)
);

// File: tb/tb.sv
// Self-checking bench for irc_parameter_tokenizer_unit: drives message bytes,
// predicts every parameter and compares the result stream field by field.
// Depends on irc_tok_pkg, irc_tok_in_if, irc_tok_out_if and the RTL top level.
module tb;
	import irc_tok_pkg::*;

	localparam int unsigned MSG_BYTES   = MAX_MESSAGE_BYTES_DEF;
	localparam int unsigned CYCLE_LIMIT = 500000;
	localparam int unsigned STALL_GAP   = 1000;
	localparam int unsigned STALL_LEN   = 90;
	localparam int unsigned SETTLE      = 8;

	typedef struct {
		logic [7:0] c;
		logic       eom;
	} msg_byte_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [4:0] cfg_wr_data;

	irc_tok_in_if  msg_if();
	irc_tok_out_if tok_if();

	irc_parameter_tokenizer_unit #(
		.MAX_MESSAGE_BYTES(MSG_BYTES)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.msg_in(msg_if),
		.tok_out(tok_if)
	);

	always #10 clk = ~clk;

	msg_byte_t pending_bytes[$];
	res_t      expected_params[$];
	int unsigned param_errors = 0;
	int unsigned cycles = 0;
	int unsigned send_idle_pct = 23;
	int unsigned recv_idle_pct = 82;
	int unsigned stall_left = 0;
	int unsigned since_stall = 0;

	// tokenizer state as the bench sees it
	logic [4:0] tok_limit;
	int unsigned offs, open_start, cur_len, seen, trail_start, trail_len;
	bit tok_open, prev_space, in_trail, lim_hit, msg_done, ovl_seen;

	function automatic int unsigned limit_now();
		if (tok_limit < LIMIT_MIN)
			return 32'(LIMIT_MIN);
		if (tok_limit > LIMIT_MAX)
			return 32'(LIMIT_MAX);
		return 32'(tok_limit);
	endfunction

	function automatic void restart_message();
		offs = 0;
		open_start = 0;
		cur_len = 0;
		tok_open = 1'b1;
		seen = 1;
		prev_space = 1'b0;
		in_trail = 1'b0;
		lim_hit = 1'b0;
		msg_done = 1'b0;
		ovl_seen = 1'b0;
		trail_start = 0;
		trail_len = 0;
	endfunction

	function automatic void expect_param(int unsigned start, int unsigned len,
			int unsigned idx, bit trail, bit fin);
		res_t r;
		r.token_start  = (start > 511) ? 9'd511 : start[8:0];
		r.token_length = (len > 1023) ? 10'd1023 : len[9:0];
		r.token_index  = idx[4:0];
		r.is_trailing  = trail;
		r.final_token  = fin;
		r.overlong     = ovl_seen;
		expected_params.push_back(r);
	endfunction

	// end of message: the open token, then the trailing parameter if any
	function automatic void close_message();
		if (in_trail) begin
			expect_param(open_start, cur_len, seen - 1, 1'b0, 1'b0);
			expect_param(trail_start, trail_len, seen, 1'b1, 1'b1);
		end else begin
			expect_param(open_start, cur_len, seen - 1, 1'b0, 1'b1);
		end
	endfunction

	function automatic void scan_byte(logic [7:0] c);
		bit absorbing;
		absorbing = !in_trail && !lim_hit && seen >= limit_now();
		if (lim_hit) begin
			// rest of the message is dropped
		end else if (in_trail) begin
			trail_len++;
		end else if (c == CH_COLON && prev_space && offs > 0) begin
			if (absorbing && offs - 1 > open_start) begin
				cur_len = offs - 1 - open_start;
				lim_hit = 1'b1;
			end else begin
				if (absorbing)
					cur_len = 0;
				in_trail = 1'b1;
				trail_start = offs + 1;
				trail_len = 0;
			end
		end else if (absorbing) begin
			cur_len++;
		end else if (c == CH_SPACE) begin
			tok_open = 1'b0;
		end else if (tok_open) begin
			cur_len++;
		end else begin
			// a new token opens, so the previous one is known not to be last
			expect_param(open_start, cur_len, seen - 1, 1'b0, 1'b0);
			seen++;
			open_start = offs;
			cur_len = 1;
			tok_open = 1'b1;
		end
		prev_space = (c == CH_SPACE);
		offs++;
	endfunction

	function automatic void predict_byte(logic [7:0] c, logic eom);
		if (msg_done) begin
			if (eom)
				restart_message();
			return;
		end
		if (offs >= MSG_BYTES) begin
			ovl_seen = 1'b1;
		end else if (c == CH_NUL) begin
			close_message();
			if (eom)
				restart_message();
			else
				msg_done = 1'b1;
			return;
		end else begin
			scan_byte(c);
		end
		if (eom) begin
			close_message();
			restart_message();
		end
	endfunction

	function automatic void check_field(string name, int unsigned e, int unsigned a);
		if (e != a) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
			param_errors++;
		end
	endfunction

	// stimulus helpers
	function automatic void push_byte(logic [7:0] c, logic eom);
		msg_byte_t b;
		b.c = c;
		b.eom = eom;
		pending_bytes.push_back(b);
	endfunction

	function automatic void push_text(string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i], i == s.len() - 1);
	endfunction

	function automatic logic [7:0] word_char();
		case ($urandom_range(0, 9))
			0: return CH_COLON;
			1: return 8'($urandom_range(1, 255));
			default: return 8'h61 + 8'($urandom_range(0, 25));
		endcase
	endfunction

	function automatic logic [7:0] noise_char();
		case ($urandom_range(0, 3))
			0: return CH_SPACE;
			1: return CH_COLON;
			2: return 8'($urandom_range(0, 255));
			default: return 8'h61 + 8'($urandom_range(0, 25));
		endcase
	endfunction

	// one message, mostly well formed, returns its byte count
	function automatic int unsigned gen_message();
		logic [7:0] body[$];
		int unsigned ntok;
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 12)) body.push_back(noise_char());
		end else begin
			if ($urandom_range(0, 4) == 0)
				repeat ($urandom_range(1, 2)) body.push_back(CH_SPACE);
			ntok = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 34) : $urandom_range(1, 6);
			for (int k = 0; k < ntok; k++) begin
				repeat ($urandom_range(1, 5)) body.push_back(word_char());
				if (k != ntok - 1)
					repeat ($urandom_range(1, 3)) body.push_back(CH_SPACE);
			end
			if ($urandom_range(0, 1) == 1) begin
				body.push_back(CH_SPACE);
				body.push_back(CH_COLON);
				repeat ($urandom_range(0, 8))
					body.push_back($urandom_range(0, 3) == 0 ? CH_SPACE : word_char());
			end else if ($urandom_range(0, 3) == 0) begin
				body.push_back(CH_SPACE);
			end
			// early terminator with trailing junk
			if ($urandom_range(0, 11) == 0) begin
				body.push_back(CH_NUL);
				repeat ($urandom_range(0, 3)) body.push_back(noise_char());
			end
		end
		for (int k = 0; k < body.size(); k++)
			push_byte(body[k], k == body.size() - 1);
		return body.size();
	endfunction

	// long token 0, then space and colon on the last buffer byte, then overflow
	function automatic void gen_long_colon();
		for (int k = 0; k < MSG_BYTES - 2; k++)
			push_byte(8'h61 + 8'($urandom_range(0, 25)), 1'b0);
		push_byte(CH_SPACE, 1'b0);
		push_byte(CH_COLON, 1'b0);
		repeat (2) push_byte(word_char(), 1'b0);
		push_byte(word_char(), 1'b1);
	endfunction

	// many tokens past the buffer end, with a zero byte in the overflow
	function automatic void gen_long_tokens();
		int unsigned n;
		n = 0;
		while (n < MSG_BYTES + 30) begin
			if (n == MSG_BYTES + 8)
				push_byte(CH_NUL, 1'b0);
			else if ($urandom_range(0, 9) == 0)
				push_byte(CH_SPACE, 1'b0);
			else
				push_byte(word_char(), 1'b0);
			n++;
		end
		push_byte(word_char(), 1'b1);
	endfunction

	// wait until every request is through and every parameter has arrived
	task automatic settle();
		while (pending_bytes.size() != 0 || msg_if.valid || expected_params.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_token_limit(input logic [4:0] v);
		settle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		tok_limit = v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// byte driver
	always @(posedge clk) begin
		msg_byte_t b;
		if (arst_n) begin
			if (msg_if.valid && msg_if.ready)
				predict_byte(msg_if.char_byte, msg_if.end_of_message);
			if (msg_if.valid && !msg_if.ready) begin
				// hold the request
			end else if (pending_bytes.size() != 0 &&
					$urandom_range(0, 99) >= send_idle_pct) begin
				b = pending_bytes.pop_front();
				msg_if.valid <= 1'b1;
				msg_if.char_byte <= b.c;
				msg_if.end_of_message <= b.eom;
			end else begin
				msg_if.valid <= 1'b0;
			end
		end
	end

	// result receiver, with a long hold-off now and then to back the block up
	always @(posedge clk) begin
		if (arst_n) begin
			if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				tok_if.ready <= 1'b0;
			end else if (since_stall >= STALL_GAP && msg_if.valid) begin
				stall_left <= STALL_LEN;
				since_stall <= 0;
				tok_if.ready <= 1'b0;
			end else begin
				since_stall <= since_stall + 1;
				tok_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		res_t e;
		if (arst_n && tok_if.valid && tok_if.ready) begin
			if (expected_params.size() == 0) begin
				$display("%0t: unexpected parameter, expected none, actual start %0d length %0d",
					$time, tok_if.token_start, tok_if.token_length);
				param_errors++;
			end else begin
				e = expected_params.pop_front();
				check_field("token_start", e.token_start, tok_if.token_start);
				check_field("token_length", e.token_length, tok_if.token_length);
				check_field("token_index", e.token_index, tok_if.token_index);
				check_field("is_trailing", e.is_trailing, tok_if.is_trailing);
				check_field("final_token", e.final_token, tok_if.final_token);
				check_field("overlong", e.overlong, tok_if.overlong);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		int unsigned total;
		logic [4:0] lim;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		msg_if.valid = 1'b0;
		msg_if.char_byte = '0;
		msg_if.end_of_message = 1'b0;
		tok_if.ready = 1'b0;
		tok_limit = LIMIT_RESET;
		restart_message();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: colon at offset zero, zero byte then ignored bytes,
		// top byte value, trailing with spaces and colons, lone terminator
		push_text(":a b");
		push_byte(CH_NUL, 1'b0);
		push_byte(8'h78, 1'b0);
		push_byte(8'h79, 1'b1);
		push_byte(8'hFF, 1'b1);
		push_text("a  :c :");
		push_byte(CH_NUL, 1'b1);

		// limit one: empty prefix keeps the trailing, a real token absorbs it
		set_token_limit(LIMIT_MIN);
		push_text(" :x");
		push_text("ab :x");

		// random phases through the limit extremes and the idling regimes
		for (int p = 0; p < 6; p++) begin
			case (p)
				0: lim = LIMIT_MAX;
				1: lim = 5'd0;
				2: lim = LIMIT_RAW_TOP;
				3: lim = 5'd2;
				4: lim = 5'($urandom_range(0, 31));
				default: lim = LIMIT_RESET;
			endcase
			set_token_limit(lim);
			case (p / 2)
				0: begin
					send_idle_pct = 23;
					recv_idle_pct = 82;
				end
				1: begin
					send_idle_pct = 82;
					recv_idle_pct = 23;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			if (p == 0)
				gen_long_colon();
			if (p == 5)
				gen_long_tokens();
			total = 0;
			while (total < 70)
				total += gen_message();
		end

		settle();
		if (param_errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
